// ===== sv/bmt_pkg.sv =====
package bmt_pkg;

	// address width of the tested range
	localparam int AddrBits = 17;

	typedef logic [AddrBits-1:0] addr_t;

	// configuration register indexes
	localparam int CfgIndexBits = 1;
	typedef logic [CfgIndexBits-1:0] cfg_index_t;
	localparam cfg_index_t CFG_FIRST_ADDRESS = 1'd0;
	localparam cfg_index_t CFG_LAST_ADDRESS  = 1'd1;

	localparam addr_t FirstAddrReset = '0;
	localparam addr_t LastAddrReset  = '1;

	// input operation codes
	localparam logic OP_START    = 1'b0;
	localparam logic OP_RESPONSE = 1'b1;

	// steps within one bit of a march element
	typedef logic [1:0] sub_step_t;
	localparam sub_step_t SUB_READ   = 2'd0;
	localparam sub_step_t SUB_WRITE  = 2'd1;
	localparam sub_step_t SUB_VERIFY = 2'd2;

	typedef enum logic [2:0] {
		EL_IDLE,
		EL_W0,
		EL_UP_R0W1R1,
		EL_UP_R1W0,
		EL_DN_R0W1,
		EL_DN_R1W0,
		EL_FINAL_R0
	} march_el_t;

	typedef struct packed {
		logic       op;
		logic [7:0] read_data;
	} in_item_t;

	typedef struct packed {
		logic        cmd_valid;
		logic        cmd_write;
		addr_t       cmd_address;
		logic [7:0]  cmd_data;
		logic        error;
		logic [2:0]  fail_bit;
		logic [7:0]  fail_expected;
		logic [7:0]  fail_actual;
		logic [15:0] pass_count;
	} out_item_t;

endpackage

// ===== sv/bmt_in_reg.sv =====
module bmt_in_reg
	import bmt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  in_item_t item,
	input  logic     advance,
	output logic     valid_s1,
	output in_item_t item_s1
);

	// free when empty or when the held item moves on this cycle
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== sv/bmt_step.sv =====
module bmt_step
	import bmt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  cfg_index_t cfg_index,
	input  addr_t      cfg_data,
	input  logic       advance,
	input  in_item_t   item_s1,
	output out_item_t  step_result
);

	addr_t       first_q, last_q;
	march_el_t   el_q, nx_el;
	addr_t       addr_q, nx_addr;
	logic [2:0]  bit_q, nx_bit;
	sub_step_t   sub_q, nx_sub;
	logic [7:0]  held_q, nx_held;
	logic        halted_q, nx_halted;
	logic [15:0] passes_q, nx_passes;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= FirstAddrReset;
			last_q  <= LastAddrReset;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_FIRST_ADDRESS: first_q <= cfg_data;
				CFG_LAST_ADDRESS:  last_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		logic       bit_val;
		logic       exp_bit;
		logic       done;
		logic       up;
		logic       do_enter;
		logic       do_read;
		logic       do_write;
		logic       do_fail;
		logic       do_start;
		logic [7:0] wdata;
		march_el_t  enter_el;

		nx_el     = el_q;
		nx_addr   = addr_q;
		nx_bit    = bit_q;
		nx_sub    = sub_q;
		nx_held   = held_q;
		nx_halted = halted_q;
		nx_passes = passes_q;
		done      = 1'b0;
		do_enter  = 1'b0;
		do_read   = 1'b0;
		do_write  = 1'b0;
		do_fail   = 1'b0;
		do_start  = 1'b0;
		wdata     = 8'h00;
		enter_el  = el_q;
		step_result = '0;

		bit_val = item_s1.read_data[bit_q];
		up = (el_q == EL_UP_R0W1R1) || (el_q == EL_UP_R1W0);
		exp_bit = ((el_q == EL_UP_R0W1R1) && (sub_q == SUB_VERIFY))
			|| (el_q == EL_UP_R1W0) || (el_q == EL_DN_R1W0);

		if (item_s1.op == OP_START) begin
			do_start = 1'b1;
		end else if (halted_q) begin
			do_fail = 1'b1;
		end else begin
			unique case (el_q)
				EL_W0: begin
					if (addr_q >= last_q) begin
						do_enter = 1'b1;
						enter_el = EL_UP_R0W1R1;
					end else begin
						nx_addr  = AddrBits'(addr_q + 1'b1);
						do_write = 1'b1;
					end
				end
				EL_UP_R0W1R1, EL_UP_R1W0, EL_DN_R0W1, EL_DN_R1W0: begin
					if ((sub_q == SUB_READ || sub_q == SUB_VERIFY) && bit_val != exp_bit) begin
						do_fail   = 1'b1;
						nx_halted = 1'b1;
						nx_held   = item_s1.read_data;
					end else if (sub_q == SUB_READ) begin
						nx_held  = item_s1.read_data ^ (8'd1 << bit_q);
						nx_sub   = SUB_WRITE;
						do_write = 1'b1;
						wdata    = item_s1.read_data ^ (8'd1 << bit_q);
					end else if (sub_q != SUB_VERIFY && el_q == EL_UP_R0W1R1) begin
						nx_sub  = SUB_VERIFY;
						do_read = 1'b1;
					end else begin
						// this bit is finished, step bit then address
						nx_sub = SUB_READ;
						if (up) begin
							if (bit_q != 3'd7) begin
								nx_bit = 3'(bit_q + 3'd1);
							end else begin
								nx_bit = 3'd0;
								if (addr_q >= last_q) done = 1'b1;
								else nx_addr = AddrBits'(addr_q + 1'b1);
							end
						end else begin
							if (bit_q != 3'd0) begin
								nx_bit = 3'(bit_q - 3'd1);
							end else begin
								nx_bit = 3'd7;
								if (addr_q <= first_q) done = 1'b1;
								else nx_addr = AddrBits'(addr_q - 1'b1);
							end
						end
						if (done) begin
							do_enter = 1'b1;
							unique case (el_q)
								EL_UP_R0W1R1: enter_el = EL_UP_R1W0;
								EL_UP_R1W0:   enter_el = EL_DN_R0W1;
								EL_DN_R0W1:   enter_el = EL_DN_R1W0;
								default:      enter_el = EL_FINAL_R0;
							endcase
						end else begin
							do_read = 1'b1;
						end
					end
				end
				EL_FINAL_R0: begin
					if (item_s1.read_data != 8'h00) begin
						do_fail   = 1'b1;
						nx_halted = 1'b1;
						nx_held   = item_s1.read_data;
					end else if (addr_q >= last_q) begin
						nx_passes = 16'(passes_q + 16'd1);
						do_start  = 1'b1;
					end else begin
						nx_addr = AddrBits'(addr_q + 1'b1);
						do_read = 1'b1;
					end
				end
				default: ;
			endcase
		end

		if (do_start) begin
			nx_halted = 1'b0;
			nx_el     = EL_W0;
			nx_addr   = first_q;
			nx_bit    = 3'd0;
			nx_sub    = SUB_READ;
			do_write  = 1'b1;
		end

		if (do_enter) begin
			nx_el  = enter_el;
			nx_sub = SUB_READ;
			if (enter_el == EL_DN_R0W1 || enter_el == EL_DN_R1W0) begin
				nx_addr = last_q;
				nx_bit  = 3'd7;
			end else begin
				nx_addr = first_q;
				nx_bit  = 3'd0;
			end
			do_read = 1'b1;
		end

		if (do_fail) begin
			step_result.error         = 1'b1;
			step_result.cmd_address   = addr_q;
			step_result.fail_bit      = (el_q == EL_FINAL_R0) ? 3'd0 : bit_q;
			step_result.fail_expected = {7'd0, exp_bit};
			step_result.fail_actual   = nx_held;
		end else if (do_read || do_write) begin
			step_result.cmd_valid   = 1'b1;
			step_result.cmd_write   = do_write;
			step_result.cmd_address = nx_addr;
			step_result.cmd_data    = do_write ? wdata : 8'h00;
		end
		step_result.pass_count = nx_passes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			el_q     <= EL_IDLE;
			addr_q   <= '0;
			bit_q    <= 3'd0;
			sub_q    <= SUB_READ;
			held_q   <= 8'h00;
			halted_q <= 1'b0;
			passes_q <= 16'd0;
		end else if (advance) begin
			el_q     <= nx_el;
			addr_q   <= nx_addr;
			bit_q    <= nx_bit;
			sub_q    <= nx_sub;
			held_q   <= nx_held;
			halted_q <= nx_halted;
			passes_q <= nx_passes;
		end
	end

	// a halt only happens inside a running pass
	a_halt_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> el_q != EL_IDLE)
		else $error("halted with no pass running");

	// sub steps beyond the first only in the per-bit elements
	a_sub_in_bit_el: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q != SUB_READ |-> (el_q == EL_UP_R0W1R1 || el_q == EL_UP_R1W0
			|| el_q == EL_DN_R0W1 || el_q == EL_DN_R1W0))
		else $error("sub step outside a bit element");

	// a start always lands in the write-zero sweep with the error cleared
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.op == OP_START |=> el_q == EL_W0 && !halted_q)
		else $error("start did not begin a clean pass");

	// the pass counter only ever steps by one
	a_pass_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(passes_q) |-> passes_q == 16'($past(passes_q) + 16'd1))
		else $error("pass counter jumped");

endmodule

// ===== sv/bmt_out_reg.sv =====
module bmt_out_reg
	import bmt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t step_result,
	output logic      out_free,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic      valid_s2;
	out_item_t result_s2;

	// takes a new result when empty or when the held one leaves now
	assign out_free     = !valid_s2 || result_ready;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= step_result;
		end
	end

endmodule

// ===== sv/bitwise_march_memory_test.sv =====
// channel   direction  handshake                    payload
// item      in         item_valid / item_ready      item (op, read_data)
// result    out        result_valid / result_ready  result (command and check status)
// cfg       in         cfg_write_en                 cfg_index, cfg_data
//
// one transfer in gives one transfer out, through the input register and the result register
// a new item can be taken every cycle while results are taken; the march step logic
// between the input register and the result register keeps the one-item-per-cycle rate
// a stalled result only blocks the input once both registers are full
// arst_n clears the march state and the pass count, and resets the first address to zero and the last to all ones
module bitwise_march_memory_test
	import bmt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  in_item_t   item,
	output logic       result_valid,
	input  logic       result_ready,
	output out_item_t  result,
	input  logic       cfg_write_en,
	input  cfg_index_t cfg_index,
	input  addr_t      cfg_data
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_free;
	logic      advance;
	out_item_t step_result;

	// the held item is worked on in the cycle the result register can take it
	assign advance = valid_s1 && out_free;

	// input register: holds one response or start request
	bmt_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// march sequencer: checks the response, steps element, bit and address,
	// and forms the next memory command or the failure report
	bmt_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.advance      (advance),
		.item_s1      (item_s1),
		.step_result  (step_result)
	);

	// result register: parts the result side from the input side
	bmt_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.step_result  (step_result),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
